// ===== design/bsc_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bsc_pkg: shared types and constants for the bright spot cluster boxes block
// Register codes, reset values, field widths, controller states and the
// control group that the controller drives into every cluster cell.
// ---------------------------------------------------------------------------
`default_nettype none

package bsc_pkg;

  // Parameter defaults
  localparam int MAX_CLUSTERS_DEF = 30;
  localparam int COORD_BITS_DEF   = 11;

  // Fixed field widths
  localparam int PIX_W    = 8;
  localparam int NEAR_W   = 20;
  localparam int DIAM_W   = 11;
  localparam int OIDX_W   = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 20;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THRESH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SMALL  = 2'd2;

  // Register reset values
  localparam logic [PIX_W-1:0]  THRESH_RST = 8'd200;
  localparam logic [NEAR_W-1:0] NEAR_RST   = 20'd100;
  localparam logic [DIAM_W-1:0] SMALL_RST  = 11'd10;

  // Span given to a freshly opened cluster
  localparam int NEW_SPAN = 2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_READ
  } state_t;

  // Control group broadcast to the cell chain
  typedef struct packed {
    logic create;  // open a new cluster in the cell holding the token
    logic kill;    // search done: drop the token everywhere
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== design/bsc_cell.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bsc_cell: one cluster slot of the chain
// Holds one cluster's bounds, center, span and join limit. A search token
// enters from the previous cell; the cell holding it tests the pixel and
// either takes it, opens a new cluster, or hands the token on.
// ---------------------------------------------------------------------------
`default_nettype none

module bsc_cell #(
  parameter int COORD_BITS = bsc_pkg::COORD_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire bsc_pkg::cell_ctl_t        ctl,
  input  wire logic [COORD_BITS-1:0]     pix_row,
  input  wire logic [COORD_BITS-1:0]     pix_col,
  input  wire logic [bsc_pkg::DIAM_W-1:0] small_diam,
  input  wire logic [bsc_pkg::NEAR_W-1:0] near_sq,
  input  wire logic                      tok_i,
  output logic                           tok_o,
  output logic                           hit_o,
  output logic [COORD_BITS-1:0]          row_lo_o,
  output logic [COORD_BITS-1:0]          row_hi_o,
  output logic [COORD_BITS-1:0]          col_lo_o,
  output logic [COORD_BITS-1:0]          col_hi_o
);

  localparam int SQ_W = 2 * COORD_BITS;
  localparam int DW   = (SQ_W + 5 > bsc_pkg::NEAR_W) ? SQ_W + 5 : bsc_pkg::NEAR_W;

  logic                  tok_r;
  logic [COORD_BITS-1:0] row_lo_r, row_hi_r, col_lo_r, col_hi_r;
  logic [COORD_BITS-1:0] cen_row_r, cen_col_r, span_r;
  logic [DW-1:0]         lim_r;

  logic [COORD_BITS-1:0] dr, dc;
  logic [SQ_W-1:0]       dr_sq, dc_sq, sp_sq;
  logic [DW-1:0]         d2, lim_nxt;
  logic                  is_small, match;

  logic [COORD_BITS-1:0] row_lo_nxt, row_hi_nxt, col_lo_nxt, col_hi_nxt;
  logic [COORD_BITS-1:0] hgt, wid;
  logic [COORD_BITS:0]   rsum, csum;
  logic                  changed;

  // Distance test against the stored center
  always_comb begin
    dr       = (pix_row > cen_row_r) ? pix_row - cen_row_r : cen_row_r - pix_row;
    dc       = (pix_col > cen_col_r) ? pix_col - cen_col_r : cen_col_r - pix_col;
    dr_sq    = SQ_W'(dr) * SQ_W'(dr);
    dc_sq    = SQ_W'(dc) * SQ_W'(dc);
    d2       = DW'(dr_sq) + DW'(dc_sq);
    is_small = DW'(span_r) < DW'(small_diam);
    match    = is_small ? (d2 <= DW'(near_sq)) : ((d2 << 4) <= lim_r);
  end

  // Join limit 9*span^2, held in a register that is fed from the span
  always_comb begin
    sp_sq   = SQ_W'(span_r) * SQ_W'(span_r);
    lim_nxt = (DW'(sp_sq) << 3) + DW'(sp_sq);
  end

  // Widen bounds and recompute center and span
  always_comb begin
    row_lo_nxt = row_lo_r;
    row_hi_nxt = row_hi_r;
    col_lo_nxt = col_lo_r;
    col_hi_nxt = col_hi_r;
    changed    = 1'b0;
    if (pix_row < row_lo_r) begin
      row_lo_nxt = pix_row;
      changed    = 1'b1;
    end else if (pix_row > row_hi_r) begin
      row_hi_nxt = pix_row;
      changed    = 1'b1;
    end
    if (pix_col < col_lo_r) begin
      col_lo_nxt = pix_col;
      changed    = 1'b1;
    end else if (pix_col > col_hi_r) begin
      col_hi_nxt = pix_col;
      changed    = 1'b1;
    end
    rsum = (COORD_BITS+1)'(row_lo_nxt) + (COORD_BITS+1)'(row_hi_nxt);
    csum = (COORD_BITS+1)'(col_lo_nxt) + (COORD_BITS+1)'(col_hi_nxt);
    hgt  = row_hi_nxt - row_lo_nxt;
    wid  = col_hi_nxt - col_lo_nxt;
  end

  assign hit_o = tok_r & match;
  assign tok_o = tok_r;

  // Pass the token down the chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
    end else begin
      tok_r <= tok_i & ~ctl.kill;
    end
  end

  // Cluster contents
  always_ff @(posedge clk) begin
    lim_r <= lim_nxt;
    if (tok_r && ctl.create) begin
      row_lo_r  <= pix_row;
      row_hi_r  <= pix_row;
      col_lo_r  <= pix_col;
      col_hi_r  <= pix_col;
      cen_row_r <= pix_row;
      cen_col_r <= pix_col;
      span_r    <= COORD_BITS'(bsc_pkg::NEW_SPAN);
    end else if (hit_o && changed) begin
      row_lo_r  <= row_lo_nxt;
      row_hi_r  <= row_hi_nxt;
      col_lo_r  <= col_lo_nxt;
      col_hi_r  <= col_hi_nxt;
      cen_row_r <= rsum[COORD_BITS:1];
      cen_col_r <= csum[COORD_BITS:1];
      span_r    <= (wid < hgt) ? hgt : wid;
    end
  end

  assign row_lo_o = row_lo_r;
  assign row_hi_o = row_hi_r;
  assign col_lo_o = col_lo_r;
  assign col_hi_o = col_hi_r;

endmodule

`default_nettype wire

// ===== design/bright_spot_cluster_boxes.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bright_spot_cluster_boxes: group lit pixels into clusters, report boxes
// Lit pixels walk a chain of cluster cells; the first cell in range takes
// the pixel. On the frame's last pixel every box is read out and cleared.
// ---------------------------------------------------------------------------
//  channel | dir | handshake           | content
//  in_     | in  | in_tvalid/in_tready | tdata: row, col, value; tlast: frame end
//  out_    | out | tvalid/tready       | tdata: index, bounds, total; tuser: none
//          |     |                     | found; tlast: last box of the readout
//  cfg_    | in  | cfg_valid/cfg_ready | cfg_index, cfg_data; always ready
//
//  A dark pixel is done once it is accepted. A lit pixel is searched until the
//  cell that takes it, at index k (up to the cluster count), is reached, as the
//  search token moves one cell per cycle. Readout gives one box per cycle
//  unless out_tready stalls it. Reset clears the cluster count and control;
//  no input beat is taken during a search or a readout.
// ---------------------------------------------------------------------------
`default_nettype none

module bright_spot_cluster_boxes #(
  parameter int MAX_CLUSTERS = bsc_pkg::MAX_CLUSTERS_DEF,
  parameter int COORD_BITS   = bsc_pkg::COORD_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  // pixel_row, pixel_col, pixel_value (low bit up), zero padded
  input  wire logic [((2*COORD_BITS+bsc_pkg::PIX_W+7)/8)*8-1:0] in_tdata,
  input  wire logic in_tvalid,
  input  wire logic in_tlast,
  output logic      in_tready,
  // cluster_index, box_row_min, box_row_max, box_col_min, box_col_max,
  // cluster_total (low bit up), zero padded
  output logic [((2*bsc_pkg::OIDX_W+4*COORD_BITS+7)/8)*8-1:0] out_tdata,
  // none_found
  output logic      out_tuser,
  output logic      out_tlast,
  output logic      out_tvalid,
  input  wire logic out_tready,
  input  wire logic                            cfg_valid,
  input  wire logic [bsc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [bsc_pkg::CFG_DAT_W-1:0]   cfg_data,
  output logic                                 cfg_ready
);

  localparam int ODW = ((2*bsc_pkg::OIDX_W+4*COORD_BITS+7)/8)*8;
  localparam int CW  = $clog2(MAX_CLUSTERS+1);
  localparam int IW  = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;

  bsc_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   k_r, k_nxt, used_r, used_nxt;
  logic [COORD_BITS-1:0] prow_r, pcol_r;
  logic            fend_r;

  logic [bsc_pkg::PIX_W-1:0]  thresh_r;
  logic [bsc_pkg::NEAR_W-1:0] near_r;
  logic [bsc_pkg::DIAM_W-1:0] small_r;

  logic           out_valid_r, out_valid_nxt;
  logic [ODW-1:0] out_data_r, out_data_nxt;
  logic           out_last_r, out_last_nxt, out_user_r, out_user_nxt;

  bsc_pkg::cell_ctl_t ctl;
  logic in_acc, lit, slot_free;

  logic [MAX_CLUSTERS:0]   tok;
  logic [MAX_CLUSTERS-1:0] hit;
  logic [COORD_BITS-1:0]   rlo [MAX_CLUSTERS];
  logic [COORD_BITS-1:0]   rhi [MAX_CLUSTERS];
  logic [COORD_BITS-1:0]   clo [MAX_CLUSTERS];
  logic [COORD_BITS-1:0]   chi [MAX_CLUSTERS];

  assign in_tready = (state_r == bsc_pkg::S_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign lit       = in_tdata[2*COORD_BITS +: bsc_pkg::PIX_W] > thresh_r;
  assign slot_free = ~out_valid_r | out_tready;
  assign cfg_ready = 1'b1;

  // Start the search token at the head of the chain
  assign tok[0] = in_acc & lit;

  genvar g;
  generate
    for (g = 0; g < MAX_CLUSTERS; g++) begin : g_cell
      bsc_cell #(.COORD_BITS(COORD_BITS)) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .pix_row    (prow_r),
        .pix_col    (pcol_r),
        .small_diam (small_r),
        .near_sq    (near_r),
        .tok_i      (tok[g]),
        .tok_o      (tok[g+1]),
        .hit_o      (hit[g]),
        .row_lo_o   (rlo[g]),
        .row_hi_o   (rhi[g]),
        .col_lo_o   (clo[g]),
        .col_hi_o   (chi[g])
      );
    end
  endgenerate

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= bsc_pkg::THRESH_RST;
      near_r   <= bsc_pkg::NEAR_RST;
      small_r  <= bsc_pkg::SMALL_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        bsc_pkg::REG_THRESH: thresh_r <= cfg_data[bsc_pkg::PIX_W-1:0];
        bsc_pkg::REG_NEAR:   near_r   <= cfg_data[bsc_pkg::NEAR_W-1:0];
        bsc_pkg::REG_SMALL:  small_r  <= cfg_data[bsc_pkg::DIAM_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold the accepted pixel
  always_ff @(posedge clk) begin
    if (in_acc) begin
      prow_r <= in_tdata[COORD_BITS-1:0];
      pcol_r <= in_tdata[2*COORD_BITS-1:COORD_BITS];
      fend_r <= in_tlast;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bsc_pkg::S_IDLE;
      k_r         <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    out_user_r <= out_user_nxt;
  end

  // Next state, search and readout
  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    used_nxt      = used_r;
    ctl           = '0;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_user_nxt  = out_user_r;
    case (state_r)
      bsc_pkg::S_IDLE: begin
        if (in_acc) begin
          k_nxt = '0;
          if (lit) begin
            state_nxt = bsc_pkg::S_SEARCH;
          end else if (in_tlast) begin
            state_nxt = bsc_pkg::S_READ;
          end
        end
      end
      bsc_pkg::S_SEARCH: begin
        if (k_r == used_r) begin
          // no cluster took it: open one if there is room
          ctl.kill = 1'b1;
          if (used_r < CW'(MAX_CLUSTERS)) begin
            ctl.create = 1'b1;
            used_nxt   = used_r + CW'(1);
          end
        end else if (|hit) begin
          ctl.kill = 1'b1;
        end else begin
          k_nxt = k_r + CW'(1);
        end
        if (ctl.kill) begin
          k_nxt     = '0;
          state_nxt = fend_r ? bsc_pkg::S_READ : bsc_pkg::S_IDLE;
        end
      end
      bsc_pkg::S_READ: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          if (used_r == '0) begin
            out_data_nxt = '0;
            out_user_nxt = 1'b1;
            out_last_nxt = 1'b1;
            state_nxt    = bsc_pkg::S_IDLE;
          end else begin
            out_data_nxt = ODW'({bsc_pkg::OIDX_W'(used_r),
                                 chi[k_r[IW-1:0]], clo[k_r[IW-1:0]],
                                 rhi[k_r[IW-1:0]], rlo[k_r[IW-1:0]],
                                 bsc_pkg::OIDX_W'(k_r)});
            out_user_nxt = 1'b0;
            out_last_nxt = (k_r + CW'(1) == used_r);
            if (k_r + CW'(1) == used_r) begin
              used_nxt  = '0;
              k_nxt     = '0;
              state_nxt = bsc_pkg::S_IDLE;
            end else begin
              k_nxt = k_r + CW'(1);
            end
          end
        end
      end
      default: state_nxt = bsc_pkg::S_IDLE;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

endmodule

`default_nettype wire

// ===== design/bsc_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bsc_checker: port-level checks for bright_spot_cluster_boxes
// Watches the result channel over time and is bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module bsc_checker #(
  parameter int MAX_CLUSTERS = bsc_pkg::MAX_CLUSTERS_DEF,
  parameter int COORD_BITS   = bsc_pkg::COORD_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic [((2*bsc_pkg::OIDX_W+4*COORD_BITS+7)/8)*8-1:0] out_tdata,
  input wire logic out_tvalid,
  input wire logic out_tready,
  input wire logic out_tuser,
  input wire logic out_tlast
);

  localparam int TOT_LO = bsc_pkg::OIDX_W + 4*COORD_BITS;

  // Stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result beat changed");

  // Reset empties the result register
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // An empty frame reports one beat that closes the readout
  a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast &&
      out_tdata[TOT_LO +: bsc_pkg::OIDX_W] == '0)
    else $error("empty-frame beat malformed");

  // A box beat carries a nonzero cluster total
  a_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |->
      (MAX_CLUSTERS > 31) || (out_tdata[TOT_LO +: bsc_pkg::OIDX_W] != '0))
    else $error("box beat with zero cluster total");

endmodule

bind bright_spot_cluster_boxes bsc_checker #(
  .MAX_CLUSTERS(MAX_CLUSTERS),
  .COORD_BITS  (COORD_BITS)
) u_bsc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire

// ===== test/bright_spot_cluster_boxes_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bright_spot_cluster_boxes_test: self-checking bench for the cluster block
// Streams pixel frames through the block under random idling on both sides.
// A scoreboard keeps its own cluster table, predicts the box readout of each
// frame and compares every result beat field by field.
// ---------------------------------------------------------------------------
`default_nettype none

module bright_spot_cluster_boxes_test;

  localparam int NCL = bsc_pkg::MAX_CLUSTERS_DEF;
  localparam int CW = bsc_pkg::COORD_BITS_DEF;
  localparam int PIX_W = bsc_pkg::PIX_W;
  localparam int NEAR_W = bsc_pkg::NEAR_W;
  localparam int DIAM_W = bsc_pkg::DIAM_W;
  localparam int OIDX_W = bsc_pkg::OIDX_W;
  localparam int CFG_IDX_W = bsc_pkg::CFG_IDX_W;
  localparam int CFG_DAT_W = bsc_pkg::CFG_DAT_W;
  localparam int IN_W = ((2*CW+PIX_W+7)/8)*8;
  localparam int OUT_W = ((2*OIDX_W+4*CW+7)/8)*8;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 2*NCL + 8;
  localparam int LONG_HOLD = 1200;

  typedef struct packed {
    logic [OIDX_W-1:0] idx;
    logic [CW-1:0] rmin;
    logic [CW-1:0] rmax;
    logic [CW-1:0] cmin;
    logic [CW-1:0] cmax;
    logic [OIDX_W-1:0] total;
    logic none;
    logic last;
  } box_t;

  // Scoreboard: cluster table predictor plus queue of expected boxes
  class box_scoreboard;
    logic [PIX_W-1:0] thresh;
    logic [NEAR_W-1:0] near_sq;
    logic [DIAM_W-1:0] small_d;
    int used;
    logic [CW-1:0] rlo[NCL], rhi[NCL], clo[NCL], chi[NCL], crow[NCL], ccol[NCL];
    logic [DIAM_W-1:0] spn[NCL];
    box_t boxes_due[$];
    int errors;
    int frames;
    int boxes_seen;

    function new();
      thresh = bsc_pkg::THRESH_RST;
      near_sq = bsc_pkg::NEAR_RST;
      small_d = bsc_pkg::SMALL_RST;
      used = 0;
      errors = 0;
      frames = 0;
      boxes_seen = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] ri, logic [CFG_DAT_W-1:0] val);
      case (ri)
        bsc_pkg::REG_THRESH: thresh = val[PIX_W-1:0];
        bsc_pkg::REG_NEAR: near_sq = val[NEAR_W-1:0];
        bsc_pkg::REG_SMALL: small_d = val[DIAM_W-1:0];
        default: ;
      endcase
    endfunction

    function bit covers(int k, int r, int c);
      longint dr, dc, d2, s;
      dr = r - crow[k];
      dc = c - ccol[k];
      d2 = dr*dr + dc*dc;
      s = spn[k];
      if (s < small_d) return d2 <= near_sq;
      return 16*d2 <= 9*s*s;
    endfunction

    function logic [CW-1:0] mid(logic [CW-1:0] lo, logic [CW-1:0] hi);
      return (hi > lo) ? CW'((int'(lo) + int'(hi)) / 2) : lo;
    endfunction

    // Join the first cluster in range, else open a new one if room is left
    function void take(logic [CW-1:0] r, logic [CW-1:0] c);
      bit moved;
      logic [CW-1:0] h, w;
      for (int k = 0; k < used; k++) begin
        if (covers(k, r, c)) begin
          moved = 0;
          if (r < rlo[k]) begin rlo[k] = r; moved = 1; end
          else if (r > rhi[k]) begin rhi[k] = r; moved = 1; end
          if (c < clo[k]) begin clo[k] = c; moved = 1; end
          else if (c > chi[k]) begin chi[k] = c; moved = 1; end
          if (moved) begin
            h = rhi[k] - rlo[k];
            w = chi[k] - clo[k];
            spn[k] = (w < h) ? h : w;
            crow[k] = mid(rlo[k], rhi[k]);
            ccol[k] = mid(clo[k], chi[k]);
          end
          return;
        end
      end
      if (used < NCL) begin
        rlo[used] = r; rhi[used] = r; clo[used] = c; chi[used] = c;
        crow[used] = r; ccol[used] = c; spn[used] = DIAM_W'(bsc_pkg::NEW_SPAN);
        used++;
      end
    endfunction

    // Note an accepted pixel beat
    function void note_pixel(logic [CW-1:0] r, logic [CW-1:0] c,
                             logic [PIX_W-1:0] v, logic fend);
      box_t b;
      if (v > thresh) take(r, c);
      if (!fend) return;
      frames++;
      if (used == 0) begin
        b = '0;
        b.none = 1;
        b.last = 1;
        boxes_due.push_back(b);
      end
      for (int k = 0; k < used; k++) begin
        b.idx = OIDX_W'(k);
        b.rmin = rlo[k]; b.rmax = rhi[k]; b.cmin = clo[k]; b.cmax = chi[k];
        b.total = OIDX_W'(used);
        b.none = 0;
        b.last = (k == used-1);
        boxes_due.push_back(b);
      end
      used = 0;
    endfunction

    // Check one result beat against the oldest expected box
    function void check_box(logic [OUT_W-1:0] d, logic none, logic last);
      box_t e;
      box_t a;
      boxes_seen++;
      a.idx = d[4:0];
      a.rmin = d[15:5];
      a.rmax = d[26:16];
      a.cmin = d[37:27];
      a.cmax = d[48:38];
      a.total = d[53:49];
      a.none = none;
      a.last = last;
      if (boxes_due.size() == 0) begin
        $error("unexpected box beat idx=%0d", a.idx);
        errors++;
        return;
      end
      e = boxes_due.pop_front();
      if (a.idx !== e.idx) begin
        $error("cluster_index expected %0d actual %0d", e.idx, a.idx); errors++;
      end
      if (a.rmin !== e.rmin) begin
        $error("box_row_min expected %0d actual %0d", e.rmin, a.rmin); errors++;
      end
      if (a.rmax !== e.rmax) begin
        $error("box_row_max expected %0d actual %0d", e.rmax, a.rmax); errors++;
      end
      if (a.cmin !== e.cmin) begin
        $error("box_col_min expected %0d actual %0d", e.cmin, a.cmin); errors++;
      end
      if (a.cmax !== e.cmax) begin
        $error("box_col_max expected %0d actual %0d", e.cmax, a.cmax); errors++;
      end
      if (a.total !== e.total) begin
        $error("cluster_total expected %0d actual %0d", e.total, a.total); errors++;
      end
      if (a.none !== e.none) begin
        $error("none_found expected %0d actual %0d", e.none, a.none); errors++;
      end
      if (a.last !== e.last) begin
        $error("last_box expected %0d actual %0d", e.last, a.last); errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic [IN_W-1:0] in_tdata;
  logic in_tvalid, in_tlast, in_tready;
  logic [OUT_W-1:0] out_tdata;
  logic out_tuser, out_tlast, out_tvalid, out_tready;
  logic cfg_valid;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;
  logic cfg_ready;

  box_scoreboard sb;
  int cycle_cnt = 0;
  int hold_cnt = 0;
  int rx_gap = 0;
  int pixels_sent;
  logic hold_go = 1'b0;
  logic hold_done = 1'b0;

  bright_spot_cluster_boxes i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tvalid(in_tvalid), .in_tlast(in_tlast),
    .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cfg_ready(cfg_ready)
  );

  always #10 clk = ~clk;

  // Stop the run if it hangs
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("bright_spot_cluster_boxes verification failed");
      $finish;
    end
  end

  // Check each accepted result beat
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_box(out_tdata, out_tuser, out_tlast);
  end

  // Receiver: random gap after each beat, plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 0;
      hold_cnt <= 0;
      hold_done <= 0;
    end else if (hold_go && !hold_done) begin
      hold_done <= 1;
      hold_cnt <= LONG_HOLD;
      out_tready <= 0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_tready <= 0;
    end else if (out_tvalid && out_tready) begin
      rx_gap = $urandom_range(4);
      out_tready <= (rx_gap == 0);
    end else if (rx_gap > 0) begin
      rx_gap = rx_gap - 1;
      out_tready <= (rx_gap == 0);
    end else begin
      out_tready <= 1;
    end
  end

  task automatic send_pixel(int r, int c, int v, bit fend);
    int gap;
    gap = $urandom_range(4);
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {2'b00, PIX_W'(v), CW'(c), CW'(r)};
    in_tlast <= fend;
    do @(posedge clk); while (!in_tready);
    sb.note_pixel(CW'(r), CW'(c), PIX_W'(v), fend);
    pixels_sent++;
  endtask

  // Write a register once the block has drained
  task automatic write_reg(logic [CFG_IDX_W-1:0] ri, int val);
    in_tvalid <= 0;
    while (sb.boxes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= ri;
    cfg_data <= CFG_DAT_W'(val);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    sb.set_reg(ri, CFG_DAT_W'(val));
  endtask

  // One frame of bright spots with random content, noise and dark pixels
  task automatic send_spot_frame(int len);
    int sr[6], sc[6];
    int nspots, r, c, v, k;
    nspots = $urandom_range(6, 1);
    for (int i = 0; i < nspots; i++) begin
      sr[i] = $urandom_range(2047);
      sc[i] = $urandom_range(2047);
    end
    for (int i = 0; i < len; i++) begin
      k = $urandom_range(nspots-1);
      if ($urandom_range(9) == 0) begin
        r = $urandom_range(2047);
        c = $urandom_range(2047);
      end else begin
        r = (sr[k] + $urandom_range(24) - 12) & 11'h7ff;
        c = (sc[k] + $urandom_range(24) - 12) & 11'h7ff;
      end
      v = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(255, 190);
      send_pixel(r, c, v, i == len-1);
    end
  endtask

  initial begin
    rst_n = 0;
    in_tvalid = 0;
    in_tlast = 0;
    in_tdata = '0;
    cfg_valid = 0;
    cfg_index = bsc_pkg::REG_THRESH;
    cfg_data = '0;
    pixels_sent = 0;
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: empty frame, extreme coordinates and values
    send_pixel(0, 0, 0, 1);
    send_pixel(0, 0, 255, 0);
    send_pixel(2047, 2047, 255, 0);
    send_pixel(3, 4, 201, 0);
    send_pixel(2047, 0, 200, 0);
    send_pixel(12, 10, 255, 0);
    send_pixel(2047, 2046, 255, 1);

    // Directed: fill the table past its size while the receiver holds off
    hold_go <= 1'b1;
    for (int i = 0; i < NCL + 2; i++) send_pixel((i / 6) * 300, (i % 6) * 300, 255, i == NCL+1);
    send_pixel(5, 5, 255, 0);
    send_pixel(6, 7, 255, 0);
    send_pixel(40, 40, 99, 1);

    // Directed: small diameter zero, so every cluster uses the span-based range
    write_reg(bsc_pkg::REG_SMALL, 0);
    write_reg(bsc_pkg::REG_NEAR, 0);
    for (int i = 0; i < 6; i++) send_pixel(100 + 3*i, 100 + 2*i, 250, i == 5);

    // Random frames over several register settings, extremes included
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin write_reg(bsc_pkg::REG_THRESH, 200); write_reg(bsc_pkg::REG_NEAR, 100);
                 write_reg(bsc_pkg::REG_SMALL, 10); end
        1: write_reg(bsc_pkg::REG_THRESH, 0);
        2: begin write_reg(bsc_pkg::REG_THRESH, 255); end
        3: begin write_reg(bsc_pkg::REG_THRESH, 180);
                 write_reg(bsc_pkg::REG_NEAR, 1048575); end
        4: begin write_reg(bsc_pkg::REG_NEAR, 0); write_reg(bsc_pkg::REG_SMALL, 2047); end
        5: begin write_reg(bsc_pkg::REG_NEAR, $urandom_range(400));
                 write_reg(bsc_pkg::REG_SMALL, $urandom_range(40)); end
        default: begin write_reg(bsc_pkg::REG_THRESH, $urandom_range(255));
                 write_reg(bsc_pkg::REG_NEAR, $urandom_range(1048575));
                 write_reg(bsc_pkg::REG_SMALL, $urandom_range(2047)); end
      endcase
      for (int f = 0; f < 2; f++) send_spot_frame($urandom_range(36, 14));
    end

    // Drain
    in_tvalid <= 0;
    while (sb.boxes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run covered %0d pixels in %0d frames, %0d box beats checked.",
             pixels_sent, sb.frames, sb.boxes_seen);
    $display("Settings swept: threshold, near distance and small diameter extremes.");
    if (sb.errors == 0 && sb.boxes_due.size() == 0) begin
      $display("bright_spot_cluster_boxes verification clean");
    end else begin
      $display("bright_spot_cluster_boxes verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
